// ===== src/config_text_tokenizer_defines.svh =====
// Assertion macros shared by the tokenizer checker.
`ifndef CONFIG_TEXT_TOKENIZER_DEFINES_SVH
`define CONFIG_TEXT_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CTT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ctt_pkg.sv =====
// ----------------------------------------------------------------------------
// Tokenizer package
// Shared types and codes for the configuration-text tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ctt_pkg;

  // Width of the reported line number.
  localparam int LINE_W = 16;
  localparam logic [LINE_W-1:0] LINE_RPT_MAX = 16'hFFFF;

  // Most results that one input item can cause.
  localparam int MAX_RES = 4;
  localparam int CNT_W   = 3;

  // Result event codes.
  typedef enum logic [1:0] {
    EV_CHAR  = 2'd0,
    EV_END   = 2'd1,
    EV_ERROR = 2'd2,
    EV_EOT   = 2'd3
  } event_t;

  // Lexer modes.
  typedef enum logic [3:0] {
    M_IDLE       = 4'd0,
    M_IDLE_CR    = 4'd1,
    M_LINECMT    = 4'd2,
    M_BLOCK      = 4'd3,
    M_BLOCK_STAR = 4'd4,
    M_BLOCK_CR   = 4'd5,
    M_IDENT      = 4'd6,
    M_CSTR       = 4'd7,
    M_VSTR       = 4'd8,
    M_VSTR_CR    = 4'd9
  } mode_t;

  // One result without its line number.
  typedef struct packed {
    event_t     ev;
    logic [7:0] ch;
    logic       q;
  } res_t;

  // All results of one input item, as they travel through the queue.
  typedef struct packed {
    logic [CNT_W-1:0]        cnt;
    res_t [MAX_RES-1:0]      slot;
    logic [LINE_W-1:0]       line;
  } bundle_t;

endpackage

`default_nettype wire

// ===== src/ctt_fifo.sv =====
// ----------------------------------------------------------------------------
// Result bundle queue
// Short register queue that decouples the lexer from the result drain.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ctt_pkg::bundle_t  wdata,
  output logic              full,
  input  logic              pop,
  output ctt_pkg::bundle_t  rdata,
  output logic              empty
);
  import ctt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  bundle_t         mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push;
  logic            do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ctt_front.sv =====
// ----------------------------------------------------------------------------
// Tokenizer front end
// Takes one text byte per cycle while the queue has room, runs the lexer and packs its results.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_front #(
  parameter int LINE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_vld,
  input  logic [7:0]        text_byte,
  input  logic              q_full,
  output logic              q_push,
  output ctt_pkg::bundle_t  q_data
);
  import ctt_pkg::*;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [LINE_BITS-1:0] LINE_TOP = '1;

  function automatic logic is_nl(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_EQUAL);
  endfunction

  function automatic logic ends_ident(input logic [7:0] c);
    return is_blank(c) || is_nl(c) || is_op(c) || (c == CH_DQUOTE) || (c == CH_SQUOTE);
  endfunction

  mode_t                 mode_r;
  mode_t                 mode_c;
  mode_t                 dmode;
  logic                  held_r;
  logic                  held_c;
  logic                  err_r;
  logic                  err_c;
  logic [LINE_BITS-1:0]  line_r;
  logic                  bump;
  logic                  clr;
  logic                  run_disp;
  logic                  run_idle;
  logic                  run_block;
  logic                  run_vstr;
  logic [CNT_W-1:0]      n_c;
  res_t [MAX_RES-1:0]    slot_c;
  logic                  accept;
  logic [LINE_W-1:0]     line_rpt;

  assign accept = byte_vld && !q_full;

  // Reported line number clips at the port maximum.
  assign line_rpt = (line_r > LINE_BITS'(LINE_RPT_MAX)) ? LINE_RPT_MAX : LINE_W'(line_r);

  // Lexer: next mode, held flag, line bump and the list of results.
  always_comb begin
    mode_c    = mode_r;
    dmode     = mode_r;
    held_c    = held_r;
    err_c     = err_r;
    bump      = 1'b0;
    clr       = 1'b0;
    run_disp  = 1'b0;
    run_idle  = 1'b0;
    run_block = 1'b0;
    run_vstr  = 1'b0;
    n_c       = '0;
    slot_c    = '0;

    if (text_byte == CH_NUL) begin
      // End of text closes what is pending, then resets everything.
      if (!err_r) begin
        if (held_r) begin
          if (mode_r == M_CSTR) begin
            slot_c[n_c[1:0]] = '{ev: EV_ERROR, ch: 8'h00, q: 1'b0}; n_c = n_c + 1'b1;
          end else if (mode_r == M_VSTR) begin
            slot_c[n_c[1:0]] = '{ev: EV_CHAR, ch: CH_BSLASH, q: 1'b0}; n_c = n_c + 1'b1;
            slot_c[n_c[1:0]] = '{ev: EV_END, ch: 8'h00, q: 1'b1}; n_c = n_c + 1'b1;
          end else begin
            slot_c[n_c[1:0]] = '{ev: EV_CHAR, ch: CH_SLASH, q: 1'b0}; n_c = n_c + 1'b1;
            slot_c[n_c[1:0]] = '{ev: EV_END, ch: 8'h00, q: 1'b0}; n_c = n_c + 1'b1;
          end
        end else if (mode_r == M_IDENT) begin
          slot_c[n_c[1:0]] = '{ev: EV_END, ch: 8'h00, q: 1'b0}; n_c = n_c + 1'b1;
        end else if ((mode_r == M_CSTR) || (mode_r == M_VSTR) || (mode_r == M_VSTR_CR)) begin
          slot_c[n_c[1:0]] = '{ev: EV_END, ch: 8'h00, q: 1'b1}; n_c = n_c + 1'b1;
        end
      end
      slot_c[n_c[1:0]] = '{ev: EV_EOT, ch: 8'h00, q: 1'b0}; n_c = n_c + 1'b1;
      clr = 1'b1;
    end else if (!err_r) begin
      // A held slash or backslash is resolved by this byte.
      if (held_r) begin
        held_c = 1'b0;
        case (mode_r)
          M_IDLE, M_IDENT: begin
            if ((text_byte == CH_SLASH) || (text_byte == CH_STAR)) begin
              if (mode_r == M_IDENT) begin
                slot_c[n_c[1:0]] = '{ev: EV_END, ch: 8'h00, q: 1'b0}; n_c = n_c + 1'b1;
              end
              mode_c = (text_byte == CH_SLASH) ? M_LINECMT : M_BLOCK;
            end else begin
              slot_c[n_c[1:0]] = '{ev: EV_CHAR, ch: CH_SLASH, q: 1'b0}; n_c = n_c + 1'b1;
              run_disp = 1'b1;
              dmode    = M_IDENT;
            end
          end
          M_CSTR: begin
            case (text_byte)
              CH_N: begin
                slot_c[n_c[1:0]] = '{ev: EV_CHAR, ch: CH_LF, q: 1'b0}; n_c = n_c + 1'b1;
              end
              CH_R: begin
                slot_c[n_c[1:0]] = '{ev: EV_CHAR, ch: CH_CR, q: 1'b0}; n_c = n_c + 1'b1;
              end
              CH_T: begin
                slot_c[n_c[1:0]] = '{ev: EV_CHAR, ch: CH_TAB, q: 1'b0}; n_c = n_c + 1'b1;
              end
              CH_SQUOTE, CH_DQUOTE, CH_BSLASH: begin
                slot_c[n_c[1:0]] = '{ev: EV_CHAR, ch: text_byte, q: 1'b0}; n_c = n_c + 1'b1;
              end
              default: begin
                slot_c[n_c[1:0]] = '{ev: EV_ERROR, ch: 8'h00, q: 1'b0}; n_c = n_c + 1'b1;
                err_c  = 1'b1;
                mode_c = M_IDLE;
              end
            endcase
          end
          M_VSTR: begin
            if (text_byte == CH_SQUOTE) begin
              slot_c[n_c[1:0]] = '{ev: EV_CHAR, ch: CH_SQUOTE, q: 1'b0}; n_c = n_c + 1'b1;
            end else begin
              slot_c[n_c[1:0]] = '{ev: EV_CHAR, ch: CH_BSLASH, q: 1'b0}; n_c = n_c + 1'b1;
              run_disp = 1'b1;
              dmode    = M_VSTR;
            end
          end
          default: begin
            run_disp = 1'b1;
          end
        endcase
      end else begin
        run_disp = 1'b1;
      end

      // Per-mode handling of the byte.
      if (run_disp) begin
        mode_c = dmode;
        case (dmode)
          M_IDLE_CR: begin
            if (text_byte != CH_LF) begin
              run_idle = 1'b1;
            end else begin
              mode_c = M_IDLE;
            end
          end
          M_LINECMT: begin
            if (is_nl(text_byte)) begin
              run_idle = 1'b1;
            end
          end
          M_BLOCK: begin
            run_block = 1'b1;
          end
          M_BLOCK_STAR: begin
            if (text_byte == CH_SLASH) begin
              mode_c = M_IDLE;
            end else begin
              run_block = 1'b1;
            end
          end
          M_BLOCK_CR: begin
            if (text_byte != CH_LF) begin
              run_block = 1'b1;
            end else begin
              mode_c = M_BLOCK;
            end
          end
          M_IDENT: begin
            if (ends_ident(text_byte)) begin
              slot_c[n_c[1:0]] = '{ev: EV_END, ch: 8'h00, q: 1'b0}; n_c = n_c + 1'b1;
              run_idle = 1'b1;
            end else if (text_byte == CH_SLASH) begin
              held_c = 1'b1;
            end else begin
              slot_c[n_c[1:0]] = '{ev: EV_CHAR, ch: text_byte, q: 1'b0}; n_c = n_c + 1'b1;
            end
          end
          M_CSTR: begin
            if (text_byte == CH_BSLASH) begin
              held_c = 1'b1;
            end else if (text_byte == CH_DQUOTE) begin
              slot_c[n_c[1:0]] = '{ev: EV_END, ch: 8'h00, q: 1'b1}; n_c = n_c + 1'b1;
              mode_c = M_IDLE;
            end else if (is_nl(text_byte)) begin
              slot_c[n_c[1:0]] = '{ev: EV_ERROR, ch: 8'h00, q: 1'b0}; n_c = n_c + 1'b1;
              err_c  = 1'b1;
              held_c = 1'b0;
              mode_c = M_IDLE;
            end else begin
              slot_c[n_c[1:0]] = '{ev: EV_CHAR, ch: text_byte, q: 1'b0}; n_c = n_c + 1'b1;
            end
          end
          M_VSTR: begin
            run_vstr = 1'b1;
          end
          M_VSTR_CR: begin
            if (text_byte != CH_LF) begin
              run_vstr = 1'b1;
            end else begin
              mode_c = M_VSTR;
            end
          end
          default: begin
            run_idle = 1'b1;
          end
        endcase
      end

      // Inside a block comment only the closing star and newlines matter.
      if (run_block) begin
        mode_c = M_BLOCK;
        if (text_byte == CH_STAR) begin
          mode_c = M_BLOCK_STAR;
        end else if (text_byte == CH_CR) begin
          bump   = 1'b1;
          mode_c = M_BLOCK_CR;
        end else if (text_byte == CH_LF) begin
          bump = 1'b1;
        end
      end

      // Apostrophe strings keep newlines as LF and count them.
      if (run_vstr) begin
        mode_c = M_VSTR;
        if (text_byte == CH_BSLASH) begin
          held_c = 1'b1;
        end else if (text_byte == CH_CR) begin
          slot_c[n_c[1:0]] = '{ev: EV_CHAR, ch: CH_LF, q: 1'b0}; n_c = n_c + 1'b1;
          bump   = 1'b1;
          mode_c = M_VSTR_CR;
        end else if (text_byte == CH_LF) begin
          slot_c[n_c[1:0]] = '{ev: EV_CHAR, ch: CH_LF, q: 1'b0}; n_c = n_c + 1'b1;
          bump = 1'b1;
        end else if (text_byte == CH_SQUOTE) begin
          slot_c[n_c[1:0]] = '{ev: EV_END, ch: 8'h00, q: 1'b1}; n_c = n_c + 1'b1;
          mode_c = M_IDLE;
        end else begin
          slot_c[n_c[1:0]] = '{ev: EV_CHAR, ch: text_byte, q: 1'b0}; n_c = n_c + 1'b1;
        end
      end

      // Between tokens: start a token, a comment candidate or a newline.
      if (run_idle) begin
        mode_c = M_IDLE;
        if (is_blank(text_byte)) begin
          mode_c = M_IDLE;
        end else if (text_byte == CH_CR) begin
          bump   = 1'b1;
          mode_c = M_IDLE_CR;
        end else if (text_byte == CH_LF) begin
          bump = 1'b1;
        end else if (text_byte == CH_SLASH) begin
          held_c = 1'b1;
        end else if (text_byte == CH_DQUOTE) begin
          mode_c = M_CSTR;
        end else if (text_byte == CH_SQUOTE) begin
          mode_c = M_VSTR;
        end else if (is_op(text_byte)) begin
          slot_c[n_c[1:0]] = '{ev: EV_CHAR, ch: text_byte, q: 1'b0}; n_c = n_c + 1'b1;
          slot_c[n_c[1:0]] = '{ev: EV_END, ch: 8'h00, q: 1'b0}; n_c = n_c + 1'b1;
        end else begin
          slot_c[n_c[1:0]] = '{ev: EV_CHAR, ch: text_byte, q: 1'b0}; n_c = n_c + 1'b1;
          mode_c = M_IDENT;
        end
      end
    end
  end

  // Lexer state register; end of text returns it to reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      held_r <= 1'b0;
      err_r  <= 1'b0;
      line_r <= '0;
    end else if (accept) begin
      if (clr) begin
        mode_r <= M_IDLE;
        held_r <= 1'b0;
        err_r  <= 1'b0;
        line_r <= '0;
      end else begin
        mode_r <= mode_c;
        held_r <= held_c;
        err_r  <= err_c;
        if (bump && (line_r != LINE_TOP)) begin
          line_r <= line_r + 1'b1;
        end
      end
    end
  end

  // Only items that cause results enter the queue.
  assign q_push      = accept && (n_c != '0);
  assign q_data.cnt  = n_c;
  assign q_data.slot = slot_c;
  assign q_data.line = line_rpt;

endmodule

`default_nettype wire

// ===== src/ctt_back.sv =====
// ----------------------------------------------------------------------------
// Tokenizer back end
// Holds one result bundle and hands out its results one per pop.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ctt_pkg::bundle_t  q_data,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [1:0]        out_event_res,
  output logic [7:0]        out_char_out,
  output logic              out_quoted,
  output logic [15:0]       out_line_number,
  output logic              out_final_result
);
  import ctt_pkg::*;

  bundle_t     bun_r;
  logic        valid_r;
  logic [1:0]  idx_r;
  logic        last;
  logic        take;
  logic        load;
  res_t        cur;

  // Current result and whether it is the last of its bundle.
  assign cur  = bun_r.slot[idx_r];
  assign last = ({1'b0, idx_r} == (bun_r.cnt - 1'b1));
  assign take = valid_r && out_pop;
  assign load = (!valid_r || (take && last)) && !q_empty;

  assign q_pop            = load;
  assign out_empty        = !valid_r;
  assign out_event_res    = cur.ev;
  assign out_char_out     = cur.ch;
  assign out_quoted       = cur.q;
  assign out_line_number  = bun_r.line;
  assign out_final_result = last;

  // Bundle payload.
  always_ff @(posedge clk) begin
    if (load) begin
      bun_r <= q_data;
    end
  end

  // Slot index and holding flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (take) begin
      if (last) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/config_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Configuration-text tokenizer
// Splits a zero-terminated byte stream into token characters and markers.
// ----------------------------------------------------------------------------
//  Channel   Ports                                   Handshake
//  input     in_text_byte                            in_push / in_full
//  result    out_event_res, out_char_out,            out_pop / out_empty
//            out_quoted, out_line_number,
//            out_final_result
//
// One text byte is taken every cycle while the bundle queue has room; the
// lexer finishes each byte in the cycle it is taken.
// Results leave one per cycle while out_pop is high and results wait; a byte
// causes zero to four of them, so the drain rate of the result side sets the
// sustained byte rate. Reset is synchronous; a byte can be taken once reset
// is released; its first result reaches the ports via the queue and bun_r.
// The queue holds QUEUE_DEPTH bundles between the lexer and the drain.
// ----------------------------------------------------------------------------
`default_nettype none

module config_text_tokenizer #(
  parameter int LINE_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_text_byte,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_event_res,
  output logic [7:0]  out_char_out,
  output logic        out_quoted,
  output logic [15:0] out_line_number,
  output logic        out_final_result
);
  import ctt_pkg::*;

  bundle_t  f_data;
  bundle_t  b_data;
  logic     f_push;
  logic     q_full;
  logic     q_empty;
  logic     b_pop;

  assign in_full = q_full;

  // Lexer.
  ctt_front #(
    .LINE_BITS (LINE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_vld  (in_push),
    .text_byte (in_text_byte),
    .q_full    (q_full),
    .q_push    (f_push),
    .q_data    (f_data)
  );

  // Bundle queue.
  ctt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_data),
    .full  (q_full),
    .pop   (b_pop),
    .rdata (b_data),
    .empty (q_empty)
  );

  // Result drain.
  ctt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_data           (b_data),
    .q_empty          (q_empty),
    .q_pop            (b_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_event_res    (out_event_res),
    .out_char_out     (out_char_out),
    .out_quoted       (out_quoted),
    .out_line_number  (out_line_number),
    .out_final_result (out_final_result)
  );

endmodule

`default_nettype wire

// ===== src/ctt_checker.sv =====
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Checks the result stream seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "config_text_tokenizer_defines.svh"

module ctt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [1:0]  out_event_res,
  input wire logic [7:0]  out_char_out,
  input wire logic        out_quoted,
  input wire logic [15:0] out_line_number,
  input wire logic        out_final_result
);
  import ctt_pkg::*;

  // Only token characters carry a character.
  `CTT_ASSERT_NOW(a_char_only_on_char, !out_empty && (out_event_res != EV_CHAR), out_char_out == 8'h00, "character on a non-character result")

  // The quoted flag only rides on token ends.
  `CTT_ASSERT_NOW(a_quoted_only_on_end, !out_empty && out_quoted, out_event_res == EV_END, "quoted flag outside a token end")

  // End of text is always the last result of its item.
  `CTT_ASSERT_NOW(a_eot_is_final, !out_empty && (out_event_res == EV_EOT), out_final_result, "end of text is not the final result")

  // A result that is not taken stays in place.
  `CTT_ASSERT_NEXT(a_result_holds, !out_empty && !out_pop, !out_empty && $stable(out_event_res) && $stable(out_char_out) && $stable(out_line_number) && $stable(out_final_result), "waiting result changed")

endmodule

bind config_text_tokenizer ctt_checker u_ctt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_event_res    (out_event_res),
  .out_char_out     (out_char_out),
  .out_quoted       (out_quoted),
  .out_line_number  (out_line_number),
  .out_final_result (out_final_result)
);

`default_nettype wire
